### hdl/dpps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpps_pkg
// shared types and constants for the dark pixel point snap block
// ----------------------------------------------------------------------------
package dpps_pkg;

   localparam int NUM_OFFSETS = 24;
   localparam int WIN_SIDE    = 7;
   localparam int WIN_CENTER  = 3;
   localparam int WIN_BITS    = WIN_SIDE * WIN_SIDE;
   localparam int IDX_BITS    = $clog2(NUM_OFFSETS);
   localparam int CNT_BITS    = 4;
   localparam int SIZE_BITS   = 13;
   localparam int OUT_BITS    = 12;
   localparam int CSR_ADDR_BITS = 2;

   localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 13'd480;

   typedef logic signed [2:0] off_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_IMAGE_WIDTH  = 2'd0,
      REG_IMAGE_HEIGHT = 2'd1
   } csr_index_type;

   // candidate offsets, nondecreasing manhattan distance
   localparam off_type OFF_DX [0:NUM_OFFSETS-1] = '{
       3'sd0,  3'sd1,  3'sd0, -3'sd1,
       3'sd1,  3'sd1, -3'sd1, -3'sd1,
       3'sd0,  3'sd2,  3'sd0, -3'sd2,
       3'sd1,  3'sd2,  3'sd2,  3'sd1,
      -3'sd1, -3'sd2, -3'sd2, -3'sd1,
       3'sd2,  3'sd2, -3'sd2, -3'sd2
   };

   localparam off_type OFF_DY [0:NUM_OFFSETS-1] = '{
      -3'sd1,  3'sd0,  3'sd1,  3'sd0,
      -3'sd1,  3'sd1,  3'sd1, -3'sd1,
      -3'sd2,  3'sd0,  3'sd2,  3'sd0,
      -3'sd2, -3'sd1,  3'sd1,  3'sd2,
       3'sd2,  3'sd1, -3'sd1, -3'sd2,
      -3'sd2,  3'sd2,  3'sd2, -3'sd2
   };

   // best-so-far record that travels along the cell row
   typedef struct packed {
      logic                valid;
      logic [WIN_BITS-1:0] win;
      logic [CNT_BITS-1:0] cnt;
      logic [IDX_BITS-1:0] idx;
   } track_type;

endpackage

### hdl/dark_pixel_point_snap.sv
`timescale 1ns / 1ps
// pipeline: an accepted transaction passes through one masking stage, 24 offset cells
//   and one output register before its result strobe
// throughput: one transaction per cycle, busy stays low once out of reset
// reset: synchronous; clears all valid bits, loads 640 x 480, busy high during reset
// the receiver cannot stall the result strobe
// ----------------------------------------------------------------------------
// dark_pixel_point_snap
// snaps a keypoint onto the best-supported nearby black pixel
// ----------------------------------------------------------------------------
module dark_pixel_point_snap #(
   parameter int COORD_BITS = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [COORD_BITS-1:0]                  req_key_x,
   input  logic [COORD_BITS-1:0]                  req_key_y,
   input  logic [dpps_pkg::WIN_BITS-1:0]          req_window_black,
   output logic                                   rsp_valid,
   output logic                                   rsp_found,
   output logic [dpps_pkg::OUT_BITS-1:0]          rsp_snapped_x,
   output logic [dpps_pkg::OUT_BITS-1:0]          rsp_snapped_y,
   output logic [dpps_pkg::CNT_BITS-1:0]          rsp_black_count,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [dpps_pkg::CSR_ADDR_BITS-1:0]     csr_index,
   input  logic [dpps_pkg::SIZE_BITS-1:0]         csr_wdata
);

   localparam int PIPE_DEPTH = dpps_pkg::NUM_OFFSETS + 2;

   logic                            accept;
   logic                            busy_ff;
   logic [dpps_pkg::SIZE_BITS-1:0]  width_ff, width_in;
   logic [dpps_pkg::SIZE_BITS-1:0]  height_ff, height_in;

   dpps_pkg::track_type             chain [0:dpps_pkg::NUM_OFFSETS];
   logic [COORD_BITS-1:0]           kx_chain [0:dpps_pkg::NUM_OFFSETS];
   logic [COORD_BITS-1:0]           ky_chain [0:dpps_pkg::NUM_OFFSETS];

   dpps_pkg::track_type             last;
   logic                            hit;
   logic [COORD_BITS-1:0]           snap_x, snap_y;

   logic                            out_valid_ff;
   logic                            out_found_ff, out_found_in;
   logic [dpps_pkg::OUT_BITS-1:0]   out_x_ff, out_x_in;
   logic [dpps_pkg::OUT_BITS-1:0]   out_y_ff, out_y_in;
   logic [dpps_pkg::CNT_BITS-1:0]   out_cnt_ff, out_cnt_in;

   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   // configuration registers
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dpps_pkg::REG_IMAGE_WIDTH:  width_in  = csr_wdata;
            dpps_pkg::REG_IMAGE_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= dpps_pkg::WIDTH_RESET;
         height_ff <= dpps_pkg::HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   dpps_mask #(
      .COORD_BITS (COORD_BITS)
   ) u_mask (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .key_x        (req_key_x),
      .key_y        (req_key_y),
      .window_black (req_window_black),
      .image_width  (width_ff),
      .image_height (height_ff),
      .track_out    (chain[0]),
      .key_x_out    (kx_chain[0]),
      .key_y_out    (ky_chain[0])
   );

   genvar k;
   generate
      for (k = 0; k < dpps_pkg::NUM_OFFSETS; k++) begin : g_cell
         dpps_cell #(
            .COORD_BITS (COORD_BITS),
            .CELL_IDX   (k)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .track_in  (chain[k]),
            .key_x_in  (kx_chain[k]),
            .key_y_in  (ky_chain[k]),
            .track_out (chain[k+1]),
            .key_x_out (kx_chain[k+1]),
            .key_y_out (ky_chain[k+1])
         );
      end
   endgenerate

   // output stage
   always_comb begin
      last   = chain[dpps_pkg::NUM_OFFSETS];
      hit    = (last.cnt != '0);
      snap_x = kx_chain[dpps_pkg::NUM_OFFSETS]
               + COORD_BITS'(dpps_pkg::OFF_DX[last.idx]);
      snap_y = ky_chain[dpps_pkg::NUM_OFFSETS]
               + COORD_BITS'(dpps_pkg::OFF_DY[last.idx]);
      out_found_in = hit;
      out_x_in     = hit ? dpps_pkg::OUT_BITS'(snap_x) : '0;
      out_y_in     = hit ? dpps_pkg::OUT_BITS'(snap_y) : '0;
      out_cnt_in   = last.cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      out_found_ff <= out_found_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_cnt_ff   <= out_cnt_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_found       = out_found_ff;
   assign rsp_snapped_x   = out_x_ff;
   assign rsp_snapped_y   = out_y_ff;
   assign rsp_black_count = out_cnt_ff;

   // every strobe traces back to an accepted transaction
   a_strobe_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, PIPE_DEPTH))
      else $error("result strobe without matching transaction");

   // not found means an all-zero result
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |->
         (rsp_snapped_x == '0 && rsp_snapped_y == '0 && rsp_black_count == '0))
      else $error("not-found result carries data");

   // a found candidate counts at least itself and never more than its block
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |->
         (rsp_black_count != '0 && rsp_black_count <= dpps_pkg::CNT_BITS'(9)))
      else $error("black count out of range");

   // no transaction is taken while busy
   a_no_busy_accept: assert property (@(posedge clock)
      busy |-> !accept)
      else $error("transaction accepted while busy");

endmodule

### hdl/dpps_mask.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpps_mask
// registers a transaction and clears window pixels that fall outside the image
// ----------------------------------------------------------------------------
module dpps_mask #(
   parameter int COORD_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [COORD_BITS-1:0]               key_x,
   input  logic [COORD_BITS-1:0]               key_y,
   input  logic [dpps_pkg::WIN_BITS-1:0]       window_black,
   input  logic [dpps_pkg::SIZE_BITS-1:0]      image_width,
   input  logic [dpps_pkg::SIZE_BITS-1:0]      image_height,
   output dpps_pkg::track_type                 track_out,
   output logic [COORD_BITS-1:0]               key_x_out,
   output logic [COORD_BITS-1:0]               key_y_out
);

   localparam int CMP_BITS =
      ((COORD_BITS > dpps_pkg::SIZE_BITS) ? COORD_BITS : dpps_pkg::SIZE_BITS) + 2;

   logic [dpps_pkg::WIN_SIDE-1:0] col_ok;
   logic [dpps_pkg::WIN_SIDE-1:0] row_ok;
   logic [dpps_pkg::WIN_BITS-1:0] masked;

   logic                          valid_ff, valid_in;
   logic [dpps_pkg::WIN_BITS-1:0] win_ff;
   logic [COORD_BITS-1:0]         kx_ff, ky_ff;

   genvar d, r, c;
   generate
      for (d = 0; d < dpps_pkg::WIN_SIDE; d++) begin : g_bound
         logic signed [CMP_BITS-1:0] px, py, wd, ht;
         assign px = $signed(CMP_BITS'(key_x)) + CMP_BITS'(d - dpps_pkg::WIN_CENTER);
         assign py = $signed(CMP_BITS'(key_y)) + CMP_BITS'(d - dpps_pkg::WIN_CENTER);
         assign wd = $signed(CMP_BITS'(image_width));
         assign ht = $signed(CMP_BITS'(image_height));
         assign col_ok[d] = !px[CMP_BITS-1] && (px < wd);
         assign row_ok[d] = !py[CMP_BITS-1] && (py < ht);
      end
      for (r = 0; r < dpps_pkg::WIN_SIDE; r++) begin : g_row
         for (c = 0; c < dpps_pkg::WIN_SIDE; c++) begin : g_col
            assign masked[r*dpps_pkg::WIN_SIDE + c] =
               window_black[r*dpps_pkg::WIN_SIDE + c] & row_ok[r] & col_ok[c];
         end
      end
   endgenerate

   assign valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= masked;
         kx_ff  <= key_x;
         ky_ff  <= key_y;
      end
   end

   always_comb begin
      track_out.valid = valid_ff;
      track_out.win   = win_ff;
      track_out.cnt   = '0;
      track_out.idx   = '0;
   end

   assign key_x_out = kx_ff;
   assign key_y_out = ky_ff;

endmodule

### hdl/dpps_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpps_cell
// one candidate offset: scores its 3x3 block and updates the best record
// ----------------------------------------------------------------------------
module dpps_cell #(
   parameter int COORD_BITS = 12,
   parameter int CELL_IDX   = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dpps_pkg::track_type   track_in,
   input  logic [COORD_BITS-1:0] key_x_in,
   input  logic [COORD_BITS-1:0] key_y_in,
   output dpps_pkg::track_type   track_out,
   output logic [COORD_BITS-1:0] key_x_out,
   output logic [COORD_BITS-1:0] key_y_out
);

   localparam int DX   = int'(dpps_pkg::OFF_DX[CELL_IDX]);
   localparam int DY   = int'(dpps_pkg::OFF_DY[CELL_IDX]);
   localparam int CBIT = (DY + dpps_pkg::WIN_CENTER) * dpps_pkg::WIN_SIDE
                         + DX + dpps_pkg::WIN_CENTER;

   logic [8:0]                    nbr;
   logic [dpps_pkg::CNT_BITS-1:0] score;
   logic                          take;

   logic                          valid_ff, valid_in;
   dpps_pkg::track_type           pay_ff, pay_in;
   logic [COORD_BITS-1:0]         kx_ff, ky_ff;

   genvar ay, ax;
   generate
      for (ay = 0; ay < 3; ay++) begin : g_ny
         for (ax = 0; ax < 3; ax++) begin : g_nx
            assign nbr[ay*3 + ax] = track_in.win[
               (DY + ay - 1 + dpps_pkg::WIN_CENTER) * dpps_pkg::WIN_SIDE
               + DX + ax - 1 + dpps_pkg::WIN_CENTER];
         end
      end
   endgenerate

   always_comb begin
      score = '0;
      for (int i = 0; i < 9; i++) begin
         score = score + dpps_pkg::CNT_BITS'(nbr[i]);
      end
      // strictly larger wins, so ties keep the earlier offset
      take = track_in.win[CBIT] && (score > track_in.cnt);
      pay_in = track_in;
      if (take) begin
         pay_in.cnt = score;
         pay_in.idx = dpps_pkg::IDX_BITS'(CELL_IDX);
      end
      valid_in = track_in.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pay_ff <= pay_in;
      kx_ff  <= key_x_in;
      ky_ff  <= key_y_in;
   end

   always_comb begin
      track_out       = pay_ff;
      track_out.valid = valid_ff;
   end

   assign key_x_out = kx_ff;
   assign key_y_out = ky_ff;

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives keypoints and 7x7 black masks into dark_pixel_point_snap, predicts
// the chosen candidate for every accepted transaction with a local model of
// the offset search, and compares each result strobe field by field.
// Image size registers are changed between phases while the pipe is empty.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int COORD_BITS = 12;
   localparam int N_CAND     = 24;
   localparam int DRAIN_WAIT = 30;
   localparam int STALL_LIMIT = 1000;
   localparam int PHASE_ITEMS = 190;

   localparam logic [dpps_pkg::CSR_ADDR_BITS-1:0] REG_SPARE_LO = 2'd2;
   localparam logic [dpps_pkg::CSR_ADDR_BITS-1:0] REG_SPARE_HI = 2'd3;

   // candidate offsets, same search order as the block
   localparam int CAND_DX [0:N_CAND-1] = '{
       0,  1,  0, -1,   1,  1, -1, -1,   0,  2,  0, -2,
       1,  2,  2,  1,  -1, -2, -2, -1,   2,  2, -2, -2
   };
   localparam int CAND_DY [0:N_CAND-1] = '{
      -1,  0,  1,  0,  -1,  1,  1, -1,  -2,  0,  2,  0,
      -2, -1,  1,  2,   2,  1, -1, -2,  -2,  2,  2, -2
   };

   typedef struct packed {
      logic                          found;
      logic [dpps_pkg::OUT_BITS-1:0] snapped_x;
      logic [dpps_pkg::OUT_BITS-1:0] snapped_y;
      logic [dpps_pkg::CNT_BITS-1:0] black_count;
   } snap_result_type;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               start;
   logic                               busy;
   logic [COORD_BITS-1:0]              req_key_x;
   logic [COORD_BITS-1:0]              req_key_y;
   logic [dpps_pkg::WIN_BITS-1:0]      req_window_black;
   logic                               rsp_valid;
   logic                               rsp_found;
   logic [dpps_pkg::OUT_BITS-1:0]      rsp_snapped_x;
   logic [dpps_pkg::OUT_BITS-1:0]      rsp_snapped_y;
   logic [dpps_pkg::CNT_BITS-1:0]      rsp_black_count;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [dpps_pkg::CSR_ADDR_BITS-1:0] csr_index;
   logic [dpps_pkg::SIZE_BITS-1:0]     csr_wdata;

   snap_result_type pending_snaps[$];
   int              img_width;
   int              img_height;
   int              fail_count;
   int              stall_cycles = 0;
   bit              steady_flow;

   dark_pixel_point_snap #(
      .COORD_BITS(COORD_BITS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_key_x       (req_key_x),
      .req_key_y       (req_key_y),
      .req_window_black(req_window_black),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_snapped_x   (rsp_snapped_x),
      .rsp_snapped_y   (rsp_snapped_y),
      .rsp_black_count (rsp_black_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic bit pixel_black(logic [dpps_pkg::WIN_BITS-1:0] win, int kx, int ky,
                                      int dx, int dy);
      int x;
      int y;
      x = kx + dx;
      y = ky + dy;
      if (x < 0 || y < 0 || x >= img_width || y >= img_height)
         return 1'b0;
      if (dx < -dpps_pkg::WIN_CENTER || dx > dpps_pkg::WIN_CENTER ||
          dy < -dpps_pkg::WIN_CENTER || dy > dpps_pkg::WIN_CENTER)
         return 1'b0;
      return win[(dy + dpps_pkg::WIN_CENTER) * dpps_pkg::WIN_SIDE + dx +
                 dpps_pkg::WIN_CENTER];
   endfunction

   function automatic int manhattan(int i);
      return (CAND_DX[i] < 0 ? -CAND_DX[i] : CAND_DX[i]) +
             (CAND_DY[i] < 0 ? -CAND_DY[i] : CAND_DY[i]);
   endfunction

   function automatic snap_result_type predict_snap(logic [COORD_BITS-1:0] key_x,
                                                    logic [COORD_BITS-1:0] key_y,
                                                    logic [dpps_pkg::WIN_BITS-1:0] win);
      snap_result_type r;
      int kx;
      int ky;
      int best;
      int best_cnt;
      int cnt;
      int i;
      int ax;
      int ay;
      int sx;
      int sy;
      kx = key_x;
      ky = key_y;
      best = -1;
      best_cnt = 0;
      for (i = 0; i < N_CAND; i++) begin
         if (pixel_black(win, kx, ky, CAND_DX[i], CAND_DY[i])) begin
            cnt = 0;
            for (ay = CAND_DY[i] - 1; ay <= CAND_DY[i] + 1; ay++)
               for (ax = CAND_DX[i] - 1; ax <= CAND_DX[i] + 1; ax++)
                  if (pixel_black(win, kx, ky, ax, ay))
                     cnt++;
            if (best < 0 || cnt > best_cnt) begin
               best = i;
               best_cnt = cnt;
            end else if (cnt == best_cnt && manhattan(i) < manhattan(best)) begin
               best = i;
            end
         end
      end
      r = '0;
      if (best >= 0) begin
         sx = kx + CAND_DX[best];
         sy = ky + CAND_DY[best];
         r.found       = 1'b1;
         r.snapped_x   = sx[dpps_pkg::OUT_BITS-1:0];
         r.snapped_y   = sy[dpps_pkg::OUT_BITS-1:0];
         r.black_count = best_cnt[dpps_pkg::CNT_BITS-1:0];
      end
      return r;
   endfunction

   function automatic logic [dpps_pkg::WIN_BITS-1:0] mask_bit(int dx, int dy);
      logic [dpps_pkg::WIN_BITS-1:0] m;
      m = '0;
      m[(dy + dpps_pkg::WIN_CENTER) * dpps_pkg::WIN_SIDE + dx + dpps_pkg::WIN_CENTER] = 1'b1;
      return m;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // half of the keys hug the image border or the origin, the rest are spread at random
   function automatic logic [COORD_BITS-1:0] pick_coord(int size);
      int last_c;
      int v;
      last_c = (size > 4096) ? 4095 : size - 1;
      case ($urandom_range(0, 3))
         0:       v = $urandom_range(0, 4);
         1:       v = last_c - 3 + $urandom_range(0, 6);
         2:       v = $urandom_range(0, (last_c < 0) ? 0 : last_c);
         default: v = $urandom_range(0, 4095);
      endcase
      if (v < 0)
         v = 0;
      if (v > 4095)
         v = 4095;
      return v[COORD_BITS-1:0];
   endfunction

   function automatic logic [dpps_pkg::WIN_BITS-1:0] pick_window();
      logic [63:0]                   a;
      logic [63:0]                   b;
      logic [63:0]                   c;
      logic [dpps_pkg::WIN_BITS-1:0] w;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      c = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0:       w = a[dpps_pkg::WIN_BITS-1:0] & b[dpps_pkg::WIN_BITS-1:0] &
                      c[dpps_pkg::WIN_BITS-1:0];
         1:       w = a[dpps_pkg::WIN_BITS-1:0] & b[dpps_pkg::WIN_BITS-1:0];
         2:       w = a[dpps_pkg::WIN_BITS-1:0];
         3:       w = a[dpps_pkg::WIN_BITS-1:0] | b[dpps_pkg::WIN_BITS-1:0];
         4:       w = a[dpps_pkg::WIN_BITS-1:0] | b[dpps_pkg::WIN_BITS-1:0] |
                      c[dpps_pkg::WIN_BITS-1:0];
         5:       w = mask_bit($urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3) |
                      mask_bit($urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3);
         6:       w = ~(a[dpps_pkg::WIN_BITS-1:0] & b[dpps_pkg::WIN_BITS-1:0] &
                        c[dpps_pkg::WIN_BITS-1:0]);
         default: w = ($urandom_range(0, 1) == 0) ? '0 : '1;
      endcase
      return w;
   endfunction

   function automatic int pick_size();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(1, 8);
         1:       return $urandom_range(1, 4096);
         2:       return $urandom_range(4090, 4096);
         default: return $urandom_range(4097, 8191);
      endcase
   endfunction

   task automatic send_key(input logic [COORD_BITS-1:0] kx, input logic [COORD_BITS-1:0] ky,
                           input logic [dpps_pkg::WIN_BITS-1:0] win);
      int gap;
      req_key_x        <= kx;
      req_key_y        <= ky;
      req_window_black <= win;
      start            <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      pending_snaps = {pending_snaps, predict_snap(kx, ky, win)};
      gap = steady_flow ? 0 : pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_snaps.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // leaves csr_valid high so back-to-back writes need no extra edge
   task automatic write_csr(input logic [dpps_pkg::CSR_ADDR_BITS-1:0] idx,
                            input logic [dpps_pkg::SIZE_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1)
         @(posedge clock);
      case (idx)
         dpps_pkg::REG_IMAGE_WIDTH:  img_width  = data;
         dpps_pkg::REG_IMAGE_HEIGHT: img_height = data;
         default: ;
      endcase
   endtask

   task automatic set_image_size(input int w, input int h);
      wait_drained();
      if ($urandom_range(0, 1) == 0) begin
         write_csr(dpps_pkg::REG_IMAGE_WIDTH, w[dpps_pkg::SIZE_BITS-1:0]);
         write_csr(dpps_pkg::REG_IMAGE_HEIGHT, h[dpps_pkg::SIZE_BITS-1:0]);
      end else begin
         write_csr(dpps_pkg::REG_IMAGE_HEIGHT, h[dpps_pkg::SIZE_BITS-1:0]);
         write_csr(dpps_pkg::REG_IMAGE_WIDTH, w[dpps_pkg::SIZE_BITS-1:0]);
      end
      csr_valid <= 1'b0;
   endtask

   // search order, ties and clipping at reset size
   task automatic test_candidate_search();
      send_key(12'd100, 12'd100, '0);
      send_key(12'd100, 12'd100, '1);
      send_key(12'd100, 12'd100, mask_bit(0, 0));
      send_key(12'd100, 12'd100, mask_bit(2, 2));
      send_key(12'd100, 12'd100, mask_bit(1, 1) | mask_bit(0, -1));
      send_key(12'd100, 12'd100, mask_bit(2, 2) | mask_bit(0, -2) | mask_bit(-2, 2));
      send_key(12'd100, 12'd100, 49'h1_5555_5555_5555);
      send_key(12'd0, 12'd0, '1);
      send_key(12'd639, 12'd479, '1);
      send_key(12'd640, 12'd100, '1);
      send_key(12'd700, 12'd500, '1);
      send_key(12'd4095, 12'd4095, 49'h0_AAAA_AAAA_AAAA);
   endtask

   // spare indexes, zero, tiny and oversized images
   task automatic test_image_size();
      wait_drained();
      write_csr(REG_SPARE_LO, 13'h1FFF);
      write_csr(REG_SPARE_HI, 13'h0000);
      csr_valid <= 1'b0;
      send_key(12'd639, 12'd479, '1);
      set_image_size(0, 480);
      send_key(12'd10, 12'd10, '1);
      set_image_size(1, 1);
      send_key(12'd0, 12'd0, '1);
      send_key(12'd1, 12'd1, mask_bit(-1, -1));
      set_image_size(8191, 8191);
      send_key(12'd4095, 12'd4095, mask_bit(2, 2));
      send_key(12'd4095, 12'd4095, '1);
      set_image_size(4096, 4096);
      send_key(12'd4095, 12'd4095, '1);
      set_image_size(0, 0);
      send_key(12'd0, 12'd0, '1);
   endtask

   task automatic test_random_keys();
      int phase;
      int n;
      int w;
      int h;
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       begin w = 1;    h = 2;    end
            1:       begin w = 4096; h = 4096; end
            2:       begin w = 8191; h = 8191; end
            3:       begin w = 0;    h = 3;    end
            4:       begin w = 640;  h = 480;  end
            default: begin w = pick_size(); h = pick_size(); end
         endcase
         set_image_size(w, h);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0)
               steady_flow = ($urandom_range(0, 3) == 0);
            send_key(pick_coord(w), pick_coord(h), pick_window());
         end
      end
      steady_flow = 1'b0;
   endtask

   always @(posedge clock) begin : check_snaps
      snap_result_type exp_r;
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (pending_snaps.size() == 0) begin
            $error("unexpected result transaction");
            fail_count++;
         end else begin
            exp_r = pending_snaps.pop_front();
            if (rsp_found !== exp_r.found) begin
               $error("found: expected %0d, actual %0d", exp_r.found, rsp_found);
               fail_count++;
            end
            if (rsp_snapped_x !== exp_r.snapped_x) begin
               $error("snapped_x: expected %0d, actual %0d", exp_r.snapped_x, rsp_snapped_x);
               fail_count++;
            end
            if (rsp_snapped_y !== exp_r.snapped_y) begin
               $error("snapped_y: expected %0d, actual %0d", exp_r.snapped_y, rsp_snapped_y);
               fail_count++;
            end
            if (rsp_black_count !== exp_r.black_count) begin
               $error("black_count: expected %0d, actual %0d",
                      exp_r.black_count, rsp_black_count);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1 ||
          (csr_valid === 1'b1 && csr_ready === 1'b1))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin
      fail_count       = 0;
      steady_flow      = 1'b0;
      img_width        = dpps_pkg::WIDTH_RESET;
      img_height       = dpps_pkg::HEIGHT_RESET;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_key_x        <= '0;
      req_key_y        <= '0;
      req_window_black <= '0;
      csr_valid        <= 1'b0;
      csr_index        <= '0;
      csr_wdata        <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_candidate_search();
      test_image_size();
      test_random_keys();

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_snaps.size() != 0) begin
         $error("%0d result transactions never arrived", pending_snaps.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

### files.f
hdl/dpps_pkg.sv
hdl/dpps_mask.sv
hdl/dpps_cell.sv
hdl/dark_pixel_point_snap.sv
dv/tb_top.sv
